// ===== src/efc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// efc_pkg: shared types and constants of the fly camera pose core
// Payload structs, event codes, register indexes, controller commands and
// the fixed-point constants of the angle and basis arithmetic.
// ----------------------------------------------------------------------------
package efc_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CNT_W            = 5;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 32;

  // event codes
  localparam logic [1:0] OP_MOVE    = 2'd0;
  localparam logic [1:0] OP_LOOK    = 2'd1;
  localparam logic [1:0] OP_ZOOM    = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  // move directions
  localparam logic [1:0] DIR_FORWARD  = 2'd0;
  localparam logic [1:0] DIR_BACKWARD = 2'd1;
  localparam logic [1:0] DIR_RIGHT    = 2'd2;
  localparam logic [1:0] DIR_LEFT     = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_SPEED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOK_SENS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Z     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_YAW   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PITCH = 3'd6;

  // angles in Q16.16 degrees
  localparam logic signed [31:0] YAW_HALF    = 32'sd11796480;
  localparam logic [33:0]        YAW_FULL    = 34'd23592960;
  localparam logic signed [34:0] YAW_BIAS    = 35'sd3031695360; // half + 128 turns
  localparam logic signed [31:0] RIGHT_ANGLE = 32'sd5898240;
  localparam logic signed [33:0] PITCH_LIM   = 34'sd5832704;
  localparam logic signed [31:0] CORDIC_INIT = 32'sd652032874;

  localparam logic [13:0] FOV_MIN = 14'd256;
  localparam logic [13:0] FOV_MAX = 14'd11520;
  localparam logic signed [15:0] ONE14 = 16'sd16384;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [1:0]         direction;
    logic [15:0]        delta_time;
    logic signed [23:0] x_offset;
    logic signed [23:0] y_offset;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic [13:0]        field_of_view;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_MV_SD, ST_MV_SDW, ST_MV_MUL, ST_MV_ADD, ST_ZOOM,
    ST_LK_MULX, ST_LK_YAW, ST_LK_MULY, ST_LK_PITCH, ST_RESTART, ST_WRAP,
    ST_WRAP_END, ST_CD_LOAD, ST_CD_STEP, ST_CD_SAVE, ST_FR_MUL0, ST_FR_MUL1,
    ST_FR_SET, ST_NM_SQ, ST_SQ_INIT, ST_SQ_STEP, ST_DV_INIT, ST_DV_STEP,
    ST_DV_SAVE, ST_NM_END, ST_CR, ST_DONE
  } st_t;

  typedef enum logic [4:0] {
    U_NONE, U_LATCH, U_MV_SD, U_MV_SDW, U_MV_MUL, U_MV_ADD, U_ZOOM,
    U_LK_MULX, U_LK_YAW, U_LK_MULY, U_LK_PITCH, U_RESTART, U_WRAP,
    U_WRAP_END, U_CD_LOAD, U_CD_STEP, U_CD_SAVE, U_FR_MUL0, U_FR_MUL1,
    U_FR_SET, U_NM_SQ, U_SQ_INIT, U_SQ_STEP, U_DV_INIT, U_DV_STEP,
    U_DV_SAVE, U_NM_END, U_CR, U_OUT
  } uop_t;

  typedef enum logic [1:0] {PASS_FRONT, PASS_RIGHT, PASS_UP} pass_t;

  typedef struct packed {
    uop_t             uop;
    logic [CNT_W-1:0] cnt;
    logic [1:0]       k;
    pass_t            pass;
    logic             ang_pitch;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
  } status_t;

  // arctangent of 2^-i in Q16.16 degrees
  function automatic logic signed [31:0] atan_deg(input logic [CNT_W-1:0] i);
    logic signed [31:0] a;
    case (i)
      5'd0:    a = 32'sd2949120;
      5'd1:    a = 32'sd1740967;
      5'd2:    a = 32'sd919879;
      5'd3:    a = 32'sd466945;
      5'd4:    a = 32'sd234379;
      5'd5:    a = 32'sd117304;
      5'd6:    a = 32'sd58666;
      5'd7:    a = 32'sd29335;
      5'd8:    a = 32'sd14668;
      5'd9:    a = 32'sd7334;
      5'd10:   a = 32'sd3667;
      5'd11:   a = 32'sd1833;
      5'd12:   a = 32'sd917;
      5'd13:   a = 32'sd458;
      5'd14:   a = 32'sd229;
      5'd15:   a = 32'sd115;
      5'd16:   a = 32'sd57;
      5'd17:   a = 32'sd29;
      5'd18:   a = 32'sd14;
      5'd19:   a = 32'sd7;
      5'd20:   a = 32'sd4;
      5'd21:   a = 32'sd2;
      5'd22:   a = 32'sd1;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== src/euler_fly_camera_pose_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// euler_fly_camera_pose_core: fixed-point free-look camera pose
// Keeps position, yaw, pitch, field of view and the front/right/up basis;
// every event (move, look, zoom, restart) returns the resulting pose.
//
//   channel  ports                        direction  payload
//   input    in_valid/in_stall/in_data    in         in_t (one event)
//   result   out_valid/out_stall/out_data out        out_t (pose after event)
//   config   cfg_we/cfg_index/cfg_data    in         one register per write
//
// Look and restart are the longest events: both run three vector
// normalizations, each a 32-step square root and three 32-step
// divisions on the bit-serial square-root and divider units.
// One event at a time: in_stall is high from the transfer in until the
// result moves into the output register. The output register frees the
// sequencer, so out_stall only delays the hand-off of the next result.
// Reset (rst_n low, synchronous) loads register defaults and the home pose.
// ----------------------------------------------------------------------------
module euler_fly_camera_pose_core
  import efc_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  // sequencer: walks each event through the datapath, owns result valid
  efc_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: pose, registers, multiplier, CORDIC, root and divider
  efc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== src/efc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// efc_ctrl: event sequencer of the fly camera pose core
// Steps the datapath through move, zoom, look and restart sequences and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module efc_ctrl
  import efc_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  st_t              state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       k_r, k_nxt;
  pass_t            pass_r, pass_nxt;
  logic             ang_r, ang_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    k_nxt     = k_r;
    pass_nxt  = pass_r;
    ang_nxt   = ang_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        case (status.op)
          OP_MOVE: state_nxt = ST_MV_SD;
          OP_LOOK: state_nxt = ST_LK_MULX;
          OP_ZOOM: state_nxt = ST_ZOOM;
          default: state_nxt = ST_RESTART;
        endcase
      end
      ST_MV_SD:  state_nxt = ST_MV_SDW;
      ST_MV_SDW: begin
        state_nxt = ST_MV_MUL;
        k_nxt     = 2'd0;
      end
      ST_MV_MUL: state_nxt = ST_MV_ADD;
      ST_MV_ADD: begin
        if (k_r == 2'd2) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MV_MUL;
          k_nxt     = k_r + 2'd1;
        end
      end
      ST_ZOOM:     state_nxt = ST_DONE;
      ST_LK_MULX:  state_nxt = ST_LK_YAW;
      ST_LK_YAW:   state_nxt = ST_LK_MULY;
      ST_LK_MULY:  state_nxt = ST_LK_PITCH;
      ST_LK_PITCH: state_nxt = ST_WRAP;
      ST_RESTART:  state_nxt = ST_WRAP;
      ST_WRAP: begin
        if (cnt_r == CNT_W'(7)) state_nxt = ST_WRAP_END;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_WRAP_END: begin
        state_nxt = ST_CD_LOAD;
        ang_nxt   = 1'b0;
      end
      ST_CD_LOAD: state_nxt = ST_CD_STEP;
      ST_CD_STEP: begin
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) state_nxt = ST_CD_SAVE;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_CD_SAVE: begin
        if (!ang_r) begin
          state_nxt = ST_CD_LOAD;
          ang_nxt   = 1'b1;
        end else begin
          state_nxt = ST_FR_MUL0;
        end
      end
      ST_FR_MUL0: state_nxt = ST_FR_MUL1;
      ST_FR_MUL1: state_nxt = ST_FR_SET;
      ST_FR_SET: begin
        state_nxt = ST_NM_SQ;
        pass_nxt  = PASS_FRONT;
      end
      ST_NM_SQ: begin
        if (cnt_r == CNT_W'(3)) state_nxt = ST_SQ_INIT;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_SQ_INIT: state_nxt = ST_SQ_STEP;
      ST_SQ_STEP: begin
        if (cnt_r == CNT_W'(31)) begin
          state_nxt = ST_DV_INIT;
          k_nxt     = 2'd0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DV_INIT: state_nxt = ST_DV_STEP;
      ST_DV_STEP: begin
        if (cnt_r == CNT_W'(31)) state_nxt = ST_DV_SAVE;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_DV_SAVE: begin
        if (k_r == 2'd2) begin
          state_nxt = ST_NM_END;
        end else begin
          state_nxt = ST_DV_INIT;
          k_nxt     = k_r + 2'd1;
        end
      end
      ST_NM_END: begin
        case (pass_r)
          PASS_FRONT: begin
            state_nxt = ST_NM_SQ;
            pass_nxt  = PASS_RIGHT;
          end
          PASS_RIGHT: state_nxt = ST_CR;
          default:    state_nxt = ST_DONE;
        endcase
      end
      ST_CR: begin
        if (cnt_r == CNT_W'(4)) begin
          state_nxt = ST_NM_SQ;
          pass_nxt  = PASS_UP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == ST_DONE && out_free) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_comb begin
    cmd.cnt       = cnt_r;
    cmd.k         = k_r;
    cmd.pass      = pass_r;
    cmd.ang_pitch = ang_r;
    case (state_r)
      ST_IDLE:     cmd.uop = in_valid ? U_LATCH : U_NONE;
      ST_DISPATCH: cmd.uop = U_NONE;
      ST_MV_SD:    cmd.uop = U_MV_SD;
      ST_MV_SDW:   cmd.uop = U_MV_SDW;
      ST_MV_MUL:   cmd.uop = U_MV_MUL;
      ST_MV_ADD:   cmd.uop = U_MV_ADD;
      ST_ZOOM:     cmd.uop = U_ZOOM;
      ST_LK_MULX:  cmd.uop = U_LK_MULX;
      ST_LK_YAW:   cmd.uop = U_LK_YAW;
      ST_LK_MULY:  cmd.uop = U_LK_MULY;
      ST_LK_PITCH: cmd.uop = U_LK_PITCH;
      ST_RESTART:  cmd.uop = U_RESTART;
      ST_WRAP:     cmd.uop = U_WRAP;
      ST_WRAP_END: cmd.uop = U_WRAP_END;
      ST_CD_LOAD:  cmd.uop = U_CD_LOAD;
      ST_CD_STEP:  cmd.uop = U_CD_STEP;
      ST_CD_SAVE:  cmd.uop = U_CD_SAVE;
      ST_FR_MUL0:  cmd.uop = U_FR_MUL0;
      ST_FR_MUL1:  cmd.uop = U_FR_MUL1;
      ST_FR_SET:   cmd.uop = U_FR_SET;
      ST_NM_SQ:    cmd.uop = U_NM_SQ;
      ST_SQ_INIT:  cmd.uop = U_SQ_INIT;
      ST_SQ_STEP:  cmd.uop = U_SQ_STEP;
      ST_DV_INIT:  cmd.uop = U_DV_INIT;
      ST_DV_STEP:  cmd.uop = U_DV_STEP;
      ST_DV_SAVE:  cmd.uop = U_DV_SAVE;
      ST_NM_END:   cmd.uop = U_NM_END;
      ST_CR:       cmd.uop = U_CR;
      ST_DONE:     cmd.uop = out_free ? U_OUT : U_NONE;
      default:     cmd.uop = U_NONE;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      k_r         <= 2'd0;
      pass_r      <= PASS_FRONT;
      ang_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      pass_r      <= pass_nxt;
      ang_r       <= ang_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/efc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// efc_datapath: pose state and shared arithmetic of the fly camera core
// One shared multiplier, a CORDIC unit, a bit-serial square root and a
// bit-serial divider, plus pose, configuration and result registers.
// ----------------------------------------------------------------------------
module efc_datapath
  import efc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cmd_t                  cmd,
  input  wire in_t                   in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output status_t                    status,
  output out_t                       out_data
);

  // round to nearest, ties away from zero, then shift right
  function automatic logic signed [65:0] rnd_shift(input logic signed [65:0] v,
                                                   input int unsigned s);
    logic [65:0] mag;
    logic [65:0] r;
    mag = v[65] ? 66'(-v) : 66'(v);
    r   = (mag + (66'd1 << (s - 1))) >> s;
    return v[65] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [23:0] clamp_pitch(input logic signed [33:0] v);
    logic signed [23:0] r;
    if (v > PITCH_LIM) r = 24'(PITCH_LIM);
    else if (v < -PITCH_LIM) r = 24'(-PITCH_LIM);
    else r = 24'(v);
    return r;
  endfunction

  // configuration
  logic [15:0]        move_speed_r, look_sens_r;
  logic signed [31:0] start_pos_r [3];
  logic signed [24:0] start_yaw_r;
  logic signed [23:0] start_pitch_r;

  // pose
  logic signed [31:0] pos_r [3];
  logic signed [24:0] yaw_r;
  logic signed [23:0] pitch_r;
  logic signed [15:0] fv_r [3];
  logic signed [15:0] rv_r [3];
  logic signed [15:0] uv_r [3];
  logic [13:0]        fov_r;

  // working registers
  in_t                in_r;
  out_t               out_data_r;
  logic signed [65:0] prod_r;
  logic [31:0]        sd_r;
  logic [33:0]        yacc_r;
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic               cneg_r;
  logic signed [31:0] cos_yaw_r, sin_yaw_r, cos_pitch_r, sin_pitch_r;
  logic signed [31:0] vec_r [3];
  logic signed [31:0] nrm_r [3];
  logic signed [31:0] f30_r [3];
  logic signed [31:0] r30_r [3];
  logic [63:0]        l2_r, sq_n_r, sq_root_r, dv_rem_r, dv_dsh_r;
  logic [31:0]        dv_q_r;
  logic               dv_neg_r;

  // combinational helpers
  logic signed [32:0] mul_a, mul_b;
  logic               mv_neg, mv_right;
  logic signed [65:0] mv_st;
  logic signed [33:0] mv_sum;
  logic signed [31:0] mv_pos;
  logic signed [34:0] yaw_sum;
  logic signed [33:0] pit_sum;
  logic signed [25:0] zsum;
  logic [13:0]        zclamp;
  logic [33:0]        wsub;
  logic signed [34:0] yaw_wrapped;
  logic signed [31:0] cd_ang, cd_xs, cd_ys, cd_at;
  logic signed [31:0] p30;
  logic [63:0]        sq_bit, sq_t;
  logic [31:0]        len, dv_mag;
  logic [CNT_W-1:0]   dv_bit;
  logic signed [15:0] nrm14 [3];

  assign mv_neg   = (in_r.direction == DIR_BACKWARD) || (in_r.direction == DIR_LEFT);
  assign mv_right = (in_r.direction == DIR_RIGHT) || (in_r.direction == DIR_LEFT);
  assign p30      = 32'(prod_r >>> 30);
  assign len      = sq_root_r[31:0];
  assign dv_bit   = CNT_W'(31) - cmd.cnt;

  // operand select of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.uop)
      U_MV_SD: begin
        mul_a = 33'(move_speed_r);
        mul_b = 33'(in_r.delta_time);
      end
      U_MV_MUL: begin
        mul_a = mv_right ? 33'(rv_r[cmd.k]) : 33'(fv_r[cmd.k]);
        mul_b = {1'b0, sd_r};
      end
      U_LK_MULX: begin
        mul_a = 33'(in_r.x_offset);
        mul_b = 33'(look_sens_r);
      end
      U_LK_MULY: begin
        mul_a = 33'(in_r.y_offset);
        mul_b = 33'(look_sens_r);
      end
      U_FR_MUL0: begin
        mul_a = 33'(cos_yaw_r);
        mul_b = 33'(cos_pitch_r);
      end
      U_FR_MUL1: begin
        mul_a = 33'(sin_yaw_r);
        mul_b = 33'(cos_pitch_r);
      end
      U_NM_SQ: begin
        if (cmd.cnt < CNT_W'(3)) begin
          mul_a = 33'(vec_r[cmd.cnt[1:0]]);
          mul_b = 33'(vec_r[cmd.cnt[1:0]]);
        end
      end
      U_CR: begin
        case (cmd.cnt)
          CNT_W'(0): begin
            mul_a = 33'(r30_r[2]);
            mul_b = 33'(f30_r[1]);
          end
          CNT_W'(1): begin
            mul_a = 33'(r30_r[2]);
            mul_b = 33'(f30_r[0]);
          end
          CNT_W'(2): begin
            mul_a = 33'(r30_r[0]);
            mul_b = 33'(f30_r[2]);
          end
          CNT_W'(3): begin
            mul_a = 33'(r30_r[0]);
            mul_b = 33'(f30_r[1]);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // move step, angle sums, zoom clamp
  always_comb begin
    mv_st = rnd_shift(prod_r, 22);
    if (mv_neg) mv_st = -mv_st;
    mv_sum = 34'(pos_r[cmd.k]) + 34'(mv_st);
    if (mv_sum > 34'sd2147483647) mv_pos = 32'sh7FFFFFFF;
    else if (mv_sum < -34'sd2147483648) mv_pos = 32'sh80000000;
    else mv_pos = 32'(mv_sum);

    yaw_sum = 35'(yaw_r) + 35'(rnd_shift(prod_r, 8)) + YAW_BIAS;
    pit_sum = 34'(pitch_r) + 34'(rnd_shift(prod_r, 8));

    zsum = $signed({12'b0, fov_r}) - 26'(in_r.y_offset);
    if (zsum < $signed({12'b0, FOV_MIN})) zclamp = FOV_MIN;
    else if (zsum > $signed({12'b0, FOV_MAX})) zclamp = FOV_MAX;
    else zclamp = 14'(zsum);

    wsub        = YAW_FULL << (3'd7 - cmd.cnt[2:0]);
    yaw_wrapped = $signed({1'b0, yacc_r}) - 35'(YAW_HALF);
  end

  // CORDIC, square root and divider step terms
  always_comb begin
    cd_ang = cmd.ang_pitch ? 32'(pitch_r) : 32'(yaw_r);
    cd_xs  = cx_r >>> cmd.cnt;
    cd_ys  = cy_r >>> cmd.cnt;
    cd_at  = atan_deg(cmd.cnt);
    sq_bit = 64'd1 << (6'd62 - {cmd.cnt, 1'b0});
    sq_t   = sq_root_r + sq_bit;
    dv_mag = vec_r[cmd.k][31] ? 32'(-vec_r[cmd.k]) : vec_r[cmd.k];
    for (int i = 0; i < 3; i++) begin
      nrm14[i] = 16'(rnd_shift(66'(nrm_r[i]), 16));
    end
  end

  // configuration and pose state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_speed_r  <= 16'd640;
      look_sens_r   <= 16'd6554;
      start_yaw_r   <= 25'(-RIGHT_ANGLE);
      start_pitch_r <= '0;
      yaw_r         <= 25'(-RIGHT_ANGLE);
      pitch_r       <= '0;
      fov_r         <= FOV_MAX;
      for (int i = 0; i < 3; i++) begin
        start_pos_r[i] <= '0;
        pos_r[i]       <= '0;
      end
      fv_r[0] <= '0;
      fv_r[1] <= '0;
      fv_r[2] <= -ONE14;
      rv_r[0] <= ONE14;
      rv_r[1] <= '0;
      rv_r[2] <= '0;
      uv_r[0] <= '0;
      uv_r[1] <= ONE14;
      uv_r[2] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MOVE_SPEED:  move_speed_r   <= cfg_data[15:0];
          CFG_LOOK_SENS:   look_sens_r    <= cfg_data[15:0];
          CFG_START_X:     start_pos_r[0] <= cfg_data;
          CFG_START_Y:     start_pos_r[1] <= cfg_data;
          CFG_START_Z:     start_pos_r[2] <= cfg_data;
          CFG_START_YAW:   start_yaw_r    <= cfg_data[24:0];
          CFG_START_PITCH: start_pitch_r  <= cfg_data[23:0];
          default: ;
        endcase
      end
      case (cmd.uop)
        U_MV_ADD:   pos_r[cmd.k] <= mv_pos;
        U_ZOOM:     fov_r <= zclamp;
        U_LK_PITCH: pitch_r <= clamp_pitch(pit_sum);
        U_RESTART: begin
          for (int i = 0; i < 3; i++) pos_r[i] <= start_pos_r[i];
          pitch_r <= clamp_pitch(34'(start_pitch_r));
          fov_r   <= FOV_MAX;
        end
        U_WRAP_END: yaw_r <= 25'(yaw_wrapped);
        U_NM_END: begin
          for (int i = 0; i < 3; i++) begin
            case (cmd.pass)
              PASS_FRONT: fv_r[i] <= nrm14[i];
              PASS_RIGHT: rv_r[i] <= nrm14[i];
              default:    uv_r[i] <= nrm14[i];
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (cmd.uop)
      U_LATCH:   in_r <= in_data;
      U_MV_SDW:  sd_r <= prod_r[31:0];
      U_LK_YAW:  yacc_r <= yaw_sum[33:0];
      U_RESTART: yacc_r <= 34'(35'(start_yaw_r) + YAW_BIAS);
      U_WRAP:    if (yacc_r >= wsub) yacc_r <= yacc_r - wsub;
      U_CD_LOAD: begin
        cx_r <= CORDIC_INIT;
        cy_r <= '0;
        if (cd_ang > RIGHT_ANGLE) begin
          cz_r   <= cd_ang - YAW_HALF;
          cneg_r <= 1'b1;
        end else if (cd_ang < -RIGHT_ANGLE) begin
          cz_r   <= cd_ang + YAW_HALF;
          cneg_r <= 1'b1;
        end else begin
          cz_r   <= cd_ang;
          cneg_r <= 1'b0;
        end
      end
      U_CD_STEP: begin
        if (!cz_r[31]) begin
          cx_r <= cx_r - cd_ys;
          cy_r <= cy_r + cd_xs;
          cz_r <= cz_r - cd_at;
        end else begin
          cx_r <= cx_r + cd_ys;
          cy_r <= cy_r - cd_xs;
          cz_r <= cz_r + cd_at;
        end
      end
      U_CD_SAVE: begin
        if (cmd.ang_pitch) begin
          cos_pitch_r <= cneg_r ? -cx_r : cx_r;
          sin_pitch_r <= cneg_r ? -cy_r : cy_r;
        end else begin
          cos_yaw_r <= cneg_r ? -cx_r : cx_r;
          sin_yaw_r <= cneg_r ? -cy_r : cy_r;
        end
      end
      U_FR_MUL1: vec_r[0] <= p30;
      U_FR_SET: begin
        vec_r[1] <= sin_pitch_r;
        vec_r[2] <= p30;
      end
      U_NM_SQ: begin
        if (cmd.cnt == '0) l2_r <= '0;
        else l2_r <= l2_r + prod_r[63:0];
      end
      U_SQ_INIT: begin
        sq_n_r    <= l2_r;
        sq_root_r <= '0;
      end
      U_SQ_STEP: begin
        if (sq_n_r >= sq_t) begin
          sq_n_r    <= sq_n_r - sq_t;
          sq_root_r <= (sq_root_r >> 1) + sq_bit;
        end else begin
          sq_root_r <= sq_root_r >> 1;
        end
      end
      U_DV_INIT: begin
        dv_rem_r <= ({32'b0, dv_mag} << 30) + 64'(len >> 1);
        dv_dsh_r <= 64'(len) << 31;
        dv_q_r   <= '0;
        dv_neg_r <= vec_r[cmd.k][31];
      end
      U_DV_STEP: begin
        if (dv_rem_r >= dv_dsh_r) begin
          dv_rem_r       <= dv_rem_r - dv_dsh_r;
          dv_q_r[dv_bit] <= 1'b1;
        end
        dv_dsh_r <= dv_dsh_r >> 1;
      end
      U_DV_SAVE: begin
        if (len == '0) nrm_r[cmd.k] <= '0;
        else nrm_r[cmd.k] <= dv_neg_r ? -$signed(dv_q_r) : $signed(dv_q_r);
      end
      U_NM_END: begin
        case (cmd.pass)
          PASS_FRONT: begin
            for (int i = 0; i < 3; i++) f30_r[i] <= nrm_r[i];
            vec_r[0] <= -nrm_r[2];
            vec_r[1] <= '0;
            vec_r[2] <= nrm_r[0];
          end
          PASS_RIGHT: for (int i = 0; i < 3; i++) r30_r[i] <= nrm_r[i];
          default: ;
        endcase
      end
      U_CR: begin
        case (cmd.cnt)
          CNT_W'(1): vec_r[0] <= -p30;
          CNT_W'(2): vec_r[1] <= p30;
          CNT_W'(3): vec_r[1] <= vec_r[1] - p30;
          CNT_W'(4): vec_r[2] <= p30;
          default: ;
        endcase
      end
      U_OUT: begin
        out_data_r.pos_x         <= pos_r[0];
        out_data_r.pos_y         <= pos_r[1];
        out_data_r.pos_z         <= pos_r[2];
        out_data_r.front_x       <= fv_r[0];
        out_data_r.front_y       <= fv_r[1];
        out_data_r.front_z       <= fv_r[2];
        out_data_r.up_x          <= uv_r[0];
        out_data_r.up_y          <= uv_r[1];
        out_data_r.up_z          <= uv_r[2];
        out_data_r.field_of_view <= fov_r;
      end
      default: ;
    endcase
  end

  assign status.op = in_r.opcode;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== tb/camera_pose_checker.sv =====
// ----------------------------------------------------------------------------
// camera_pose_checker: pose predictor and result comparator
// Watches the event, result and register ports of the camera pose core. It
// keeps its own copy of the pose and registers, predicts the pose after every
// accepted event, and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module camera_pose_checker
  import efc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire in_t                   in_data,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire out_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         pending,
  output int                         fail_count
);

  localparam longint HALF_TURN = 64'sd11796480;
  localparam longint FULL_TURN = 64'sd23592960;
  localparam longint QUARTER   = 64'sd5898240;
  localparam longint PITCH_MAX = 64'sd5832704;
  localparam longint GAIN_INIT = 64'sd652032874;
  localparam longint UNIT30    = 64'sd1073741824;
  localparam longint ARC_DEG [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  // register copies
  logic [15:0] speed_r, sens_r;
  logic [31:0] home_x, home_y, home_z;
  logic [24:0] home_yaw;
  logic [23:0] home_pitch;

  // pose copy
  longint pos [3];
  longint yaw, pitch;
  longint fwd [3], rgt [3], upv [3];
  longint fov;

  out_t pose_q [$];

  function automatic longint round_shift(longint v, int s);
    longint half;
    half = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint wrap_angle(longint y);
    longint r;
    r = (y + HALF_TURN) % FULL_TURN;
    if (r < 0) r += FULL_TURN;
    return r - HALF_TURN;
  endfunction

  function automatic longint floor_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // rotate in degrees; fold angles beyond a right angle and negate after
  function automatic void rotate_deg(input longint ang, output longint c,
                                     output longint s);
    longint x, y, z, nx;
    bit flip;
    x = GAIN_INIT;
    y = 0;
    z = ang;
    flip = 0;
    if (z > QUARTER) begin
      z -= HALF_TURN;
      flip = 1;
    end else if (z < -QUARTER) begin
      z += HALF_TURN;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y += x >>> i;
        z -= ARC_DEG[i];
      end else begin
        nx = x + (y >>> i);
        y -= x >>> i;
        z += ARC_DEG[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic void unit_vec(input longint v [3], output longint o [3]);
    longint unsigned l2;
    longint len;
    l2 = 0;
    for (int k = 0; k < 3; k++) l2 += longint'(v[k] * v[k]);
    len = floor_sqrt(l2);
    for (int k = 0; k < 3; k++) o[k] = (len != 0) ? round_div(v[k] * UNIT30, len) : 0;
  endfunction

  function automatic void rebuild_frame();
    longint cy, sy, cp, sp;
    longint raw [3], f [3], r [3], u [3];
    rotate_deg(yaw, cy, sy);
    rotate_deg(pitch, cp, sp);
    raw[0] = (cy * cp) >>> 30;
    raw[1] = sp;
    raw[2] = (sy * cp) >>> 30;
    unit_vec(raw, f);
    raw[0] = -f[2];
    raw[1] = 0;
    raw[2] = f[0];
    unit_vec(raw, r);
    raw[0] = -((r[2] * f[1]) >>> 30);
    raw[1] = ((r[2] * f[0]) >>> 30) - ((r[0] * f[2]) >>> 30);
    raw[2] = (r[0] * f[1]) >>> 30;
    unit_vec(raw, u);
    for (int k = 0; k < 3; k++) begin
      fwd[k] = round_shift(f[k], 16);
      rgt[k] = round_shift(r[k], 16);
      upv[k] = round_shift(u[k], 16);
    end
  endfunction

  function automatic void home_pose();
    pos = '{0, 0, 0};
    yaw = -QUARTER;
    pitch = 0;
    fwd = '{0, 0, -16384};
    rgt = '{16384, 0, 0};
    upv = '{0, 16384, 0};
    fov = FOV_MAX;
  endfunction

  function automatic out_t apply_camera_event(in_t ev);
    longint sd, st;
    out_t p;
    case (ev.opcode)
      OP_MOVE: begin
        sd = longint'(speed_r) * longint'(ev.delta_time);
        for (int k = 0; k < 3; k++) begin
          st = round_shift((ev.direction < DIR_RIGHT ? fwd[k] : rgt[k]) * sd, 22);
          if (ev.direction == DIR_BACKWARD || ev.direction == DIR_LEFT) st = -st;
          pos[k] = clip(pos[k] + st, -64'sd2147483648, 64'sd2147483647);
        end
      end
      OP_LOOK: begin
        yaw = wrap_angle(yaw + round_shift(longint'(ev.x_offset) * sens_r, 8));
        pitch = clip(pitch + round_shift(longint'(ev.y_offset) * sens_r, 8),
                     -PITCH_MAX, PITCH_MAX);
        rebuild_frame();
      end
      OP_ZOOM: begin
        fov = clip(fov - longint'(ev.y_offset), FOV_MIN, FOV_MAX);
      end
      default: begin
        pos[0] = longint'($signed(home_x));
        pos[1] = longint'($signed(home_y));
        pos[2] = longint'($signed(home_z));
        yaw = wrap_angle(longint'($signed(home_yaw)));
        pitch = clip(longint'($signed(home_pitch)), -PITCH_MAX, PITCH_MAX);
        fov = FOV_MAX;
        rebuild_frame();
      end
    endcase
    p.pos_x = 32'(pos[0]);
    p.pos_y = 32'(pos[1]);
    p.pos_z = 32'(pos[2]);
    p.front_x = 16'(fwd[0]);
    p.front_y = 16'(fwd[1]);
    p.front_z = 16'(fwd[2]);
    p.up_x = 16'(upv[0]);
    p.up_y = 16'(upv[1]);
    p.up_z = 16'(upv[2]);
    p.field_of_view = 14'(fov);
    return p;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_t e;
    if (!rst_n) begin
      speed_r = 16'd640;
      sens_r = 16'd6554;
      home_x = '0;
      home_y = '0;
      home_z = '0;
      home_yaw = 25'h1A60000; // minus 90 degrees
      home_pitch = '0;
      home_pose();
      pose_q.delete();
      pending = 0;
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MOVE_SPEED:  speed_r = cfg_data[15:0];
          CFG_LOOK_SENS:   sens_r = cfg_data[15:0];
          CFG_START_X:     home_x = cfg_data;
          CFG_START_Y:     home_y = cfg_data;
          CFG_START_Z:     home_z = cfg_data;
          CFG_START_YAW:   home_yaw = cfg_data[24:0];
          CFG_START_PITCH: home_pitch = cfg_data[23:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) pose_q.push_back(apply_camera_event(in_data));
      if (out_valid && !out_stall) begin
        if (pose_q.size() == 0) begin
          $error("result with no event outstanding");
          fail_count++;
        end else begin
          e = pose_q.pop_front();
          check_field("pos_x", e.pos_x, out_data.pos_x);
          check_field("pos_y", e.pos_y, out_data.pos_y);
          check_field("pos_z", e.pos_z, out_data.pos_z);
          check_field("front_x", e.front_x, out_data.front_x);
          check_field("front_y", e.front_y, out_data.front_y);
          check_field("front_z", e.front_z, out_data.front_z);
          check_field("up_x", e.up_x, out_data.up_x);
          check_field("up_y", e.up_y, out_data.up_y);
          check_field("up_z", e.up_z, out_data.up_z);
          check_field("field_of_view", e.field_of_view, out_data.field_of_view);
        end
      end
      pending = pose_q.size();
    end
  end

endmodule

// ===== tb/euler_fly_camera_pose_core_tb.sv =====
// ----------------------------------------------------------------------------
// euler_fly_camera_pose_core_tb: stimulus and verdict for the pose core
// Drives directed and random camera events through four register settings
// and four idle/stall mixes, with one long result hold-off. The checker
// beside the core predicts and compares every pose.
// ----------------------------------------------------------------------------
module euler_fly_camera_pose_core_tb;
  import efc_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    pending;
  int                    fail_count;

  // idle mix of the current phase, in percent
  int  idle_pct  = 0;
  int  stall_pct = 0;
  // set by stimulus to request one long receiver hold-off
  bit  hold_req  = 0;

  euler_fly_camera_pose_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  camera_pose_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver: stall at random per phase; on request hold off for a long
  // stretch so the output register fills and the core stalls its input.
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else begin
        out_stall = ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Offer one event at a falling edge and hold it until the transfer.
  task automatic send_event(in_t ev);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = ev;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic in_t make_event(logic [1:0] op, logic [1:0] dir,
                                     logic [15:0] dt, logic [23:0] xo,
                                     logic [23:0] yo);
    in_t ev;
    ev.opcode = op;
    ev.direction = dir;
    ev.delta_time = dt;
    ev.x_offset = xo;
    ev.y_offset = yo;
    return ev;
  endfunction

  // Random event: mostly moves and looks with modest offsets; full-range
  // values and noise in unused fields keep every bit moving.
  function automatic in_t random_event();
    in_t ev;
    int pick;
    ev = in_t'({4'($urandom), $urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 40)      ev.opcode = OP_MOVE;
    else if (pick < 75) ev.opcode = OP_LOOK;
    else if (pick < 92) ev.opcode = OP_ZOOM;
    else                ev.opcode = OP_RESTART;
    if ($urandom_range(0, 1)) begin
      ev.x_offset = 24'($signed($urandom_range(0, 200000)) - 100000);
      ev.y_offset = 24'($signed($urandom_range(0, 8000)) - 4000);
    end
    return ev;
  endfunction

  // Drain the core, then write one register while it sits idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_setting(logic [15:0] spd, logic [15:0] sens, logic [31:0] sx,
                              logic [31:0] sy, logic [31:0] sz, logic [24:0] syaw,
                              logic [23:0] spitch);
    write_reg(CFG_MOVE_SPEED, {16'd0, spd});
    write_reg(CFG_LOOK_SENS, {16'd0, sens});
    write_reg(CFG_START_X, sx);
    write_reg(CFG_START_Y, sy);
    write_reg(CFG_START_Z, sz);
    write_reg(CFG_START_YAW, {7'd0, syaw});
    write_reg(CFG_START_PITCH, {8'd0, spitch});
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: every event kind and direction, field extremes, yaw wrap,
    // pitch saturation, zoom clamps at both ends
    send_event(make_event(OP_MOVE, DIR_FORWARD, 16'hFFFF, 24'h0, 24'h0));
    send_event(make_event(OP_MOVE, DIR_BACKWARD, 16'h8000, 24'hFFFFFF, 24'h800000));
    send_event(make_event(OP_MOVE, DIR_RIGHT, 16'h0001, 24'h7FFFFF, 24'h7FFFFF));
    send_event(make_event(OP_MOVE, DIR_LEFT, 16'h0000, 24'h0, 24'h0));
    send_event(make_event(OP_LOOK, DIR_FORWARD, 16'h0, 24'h0, 24'h0));
    send_event(make_event(OP_LOOK, DIR_LEFT, 16'hFFFF, 24'h7FFFFF, 24'h000100));
    send_event(make_event(OP_LOOK, DIR_FORWARD, 16'h0, 24'h800000, 24'h7FFFFF));
    send_event(make_event(OP_MOVE, DIR_FORWARD, 16'hFFFF, 24'h0, 24'h0));
    send_event(make_event(OP_LOOK, DIR_FORWARD, 16'h0, 24'h000000, 24'h800000));
    send_event(make_event(OP_MOVE, DIR_RIGHT, 16'hFFFF, 24'h0, 24'h0));
    send_event(make_event(OP_LOOK, DIR_FORWARD, 16'h0, 24'h070800, 24'h0));
    send_event(make_event(OP_ZOOM, DIR_FORWARD, 16'h0, 24'h0, 24'h7FFFFF));
    send_event(make_event(OP_ZOOM, DIR_FORWARD, 16'h0, 24'h0, 24'h800000));
    send_event(make_event(OP_ZOOM, DIR_FORWARD, 16'h0, 24'h0, 24'h000A00));
    send_event(make_event(OP_ZOOM, DIR_FORWARD, 16'h0, 24'h0, 24'hFFFF00));
    send_event(make_event(OP_RESTART, DIR_LEFT, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: load_setting(16'd640, 16'd6554, 32'd0, 32'd0, 32'd0, 25'h1A60000, 24'd0);
        // fastest speed and sensitivity; start x near the top and y at the bottom
        // of the range, with yaw past a half turn and pitch past the limit
        1: load_setting(16'hFFFF, 16'hFFFF, 32'h7FFFFFF0, 32'h80000000, 32'h00012345,
                        25'h0FFFFFF, 24'h7FFFFF);
        2: load_setting(16'h0000, 16'h0000, 32'h80000010, 32'h7FFFFFFF, 32'hFFFFFFFF,
                        25'h1000000, 24'h800000);
        default: load_setting(16'($urandom), 16'($urandom), $urandom, $urandom,
                              $urandom, 25'($urandom), 24'($urandom));
      endcase
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 83; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 83; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      // restart first so the new start pose is in play, then drive hard
      // into the position limits with full-speed moves
      send_event(make_event(OP_RESTART, DIR_FORWARD, 16'h0, 24'h0, 24'h0));
      if (phase == 0) hold_req = 1;
      for (int n = 0; n < 6; n++)
        send_event(make_event(OP_MOVE, n[1:0], 16'hFFFF, 24'h0, 24'h0));
      for (int n = 0; n < 475; n++) send_event(random_event());
    end

    // drain, then allow the longest event time before the verdict
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #60000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
